FILE: hw/rtl/kfd_pkg.sv
// KISS deframer package: byte codes, status codes, register indexes and the
// transfer payload types. No dependencies; used by every other file.
`default_nettype none

package kfd_pkg;

    // KISS special bytes
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // frame type bytes
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_FLEXNET = 8'h20;
    localparam logic [7:0] TYPE_SMACK   = 8'h80;

    localparam logic [10:0] LENGTH_CAP     = 11'd1024;
    localparam logic [10:0] MAX_LENGTH_RST = 11'd256;
    localparam logic [15:0] TIMEOUT_RST    = 16'd5000;

    // input item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // configuration register indexes
    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_LENGTH = 1'b0;
    localparam t_cfg_idx CFG_TIMEOUT    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FLEXNET  = 3'd1,
        ST_SMACK    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_SMALL    = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_TIMEOUT  = 3'd6,
        ST_BADESC   = 3'd7
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [9:0] data_index;
        logic       status_valid;
        t_status    status_code;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hw/rtl/kfd_if.sv
// Valid/ready stream interfaces for the KISS deframer input and result channels.
// Depends on kfd_pkg for the payload types.
`default_nettype none

interface kfd_in_if;
    logic              valid;
    logic              ready;
    kfd_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface kfd_out_if;
    logic               valid;
    logic               ready;
    kfd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kiss_frame_deframer_core.sv
// KISS deframer top level: input register, decode logic, result register.
// Depends on kfd_pkg and the stream interfaces in kfd_if.
//
// Takes one item per transfer on i_rx (a received byte or a time tick) and
// gives at most one result per item on o_res: a decoded byte with its index
// in the frame, or a status (frame closed, overflow, timeout, bad escape).
// Items that give no result (bytes while hunting, FESC, ticks inside the
// timeout) are absorbed silently. Throughput is one item per clock while o_res
// does not stall; an item passes through the input register, then the result
// register. When the result is not taken the result register stalls, and so
// does the input register when full. Configuration (max_length at index 0,
// timeout_ticks at index 1) must be written only while no item is in flight.
`default_nettype none

module kiss_frame_deframer_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire kfd_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [15:0]       i_cfg_wdata,
    kfd_in_if.sink                 i_rx,
    kfd_out_if.source              o_res
);

    logic [10:0]        r_max_length;
    logic [15:0]        r_timeout;
    logic               r_in_valid;
    kfd_pkg::t_in_item  r_in;
    logic               r_out_valid;
    kfd_pkg::t_out_item r_out;

    logic               r_in_frame, n_in_frame;
    logic               r_esc, n_esc;
    logic [9:0]         r_count, n_count;
    logic [7:0]         r_type, n_type;
    logic [15:0]        r_tick, n_tick;

    logic               adv;
    logic               res_valid;
    kfd_pkg::t_out_item res;
    logic               dec_en;
    logic [7:0]         dec_byte;
    logic [10:0]        limit;
    logic [10:0]        count_inc;
    logic [15:0]        tick_inc;
    kfd_pkg::t_status   close_code;

    assign adv         = !r_out_valid || o_res.ready;
    assign i_rx.ready  = !r_in_valid || adv;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    assign limit     = (r_max_length > kfd_pkg::LENGTH_CAP) ? kfd_pkg::LENGTH_CAP
                                                           : r_max_length;
    assign count_inc = {1'b0, r_count} + 11'd1;
    assign tick_inc  = r_tick + 16'd1;

    always_comb begin
        if (r_count <= 10'd1) begin
            close_code = kfd_pkg::ST_SMALL;
        end else begin
            case (r_type)
                kfd_pkg::TYPE_DATA:    close_code = kfd_pkg::ST_OK;
                kfd_pkg::TYPE_FLEXNET: close_code = kfd_pkg::ST_FLEXNET;
                kfd_pkg::TYPE_SMACK:   close_code = kfd_pkg::ST_SMACK;
                default:               close_code = kfd_pkg::ST_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_count    = r_count;
        n_type     = r_type;
        n_tick     = r_tick;
        res_valid  = 1'b0;
        res        = '0;
        dec_en     = 1'b0;
        dec_byte   = r_in.rx_byte;

        if (r_in_valid) begin
            if (r_in.mode == kfd_pkg::MODE_TICK) begin
                if (r_in_frame) begin
                    if (tick_inc >= r_timeout) begin
                        n_in_frame = 1'b0;
                        n_esc      = 1'b0;
                        n_count    = '0;
                        n_tick     = '0;
                        res_valid  = 1'b1;
                        res.status_valid = 1'b1;
                        res.status_code  = kfd_pkg::ST_TIMEOUT;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end else if (!r_in_frame) begin
                if (r_in.rx_byte == kfd_pkg::FEND) begin
                    n_in_frame = 1'b1;
                    n_esc      = 1'b0;
                    n_count    = '0;
                    n_tick     = '0;
                end
            end else if (r_in.rx_byte == kfd_pkg::FEND) begin
                // closing FEND also drops any pending escape
                n_in_frame = 1'b0;
                n_esc      = 1'b0;
                n_count    = '0;
                n_tick     = '0;
                res_valid  = 1'b1;
                res.status_valid = 1'b1;
                res.status_code  = close_code;
            end else if (r_in.rx_byte == kfd_pkg::FESC) begin
                n_esc = 1'b1;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (r_in.rx_byte == kfd_pkg::TFEND) begin
                    dec_en   = 1'b1;
                    dec_byte = kfd_pkg::FEND;
                end else if (r_in.rx_byte == kfd_pkg::TFESC) begin
                    dec_en   = 1'b1;
                    dec_byte = kfd_pkg::FESC;
                end else begin
                    res_valid = 1'b1;
                    res.status_valid = 1'b1;
                    res.status_code  = kfd_pkg::ST_BADESC;
                end
            end else begin
                dec_en = 1'b1;
            end

            if (dec_en) begin
                res_valid = 1'b1;
                if (count_inc >= limit) begin
                    n_in_frame = 1'b0;
                    n_esc      = 1'b0;
                    n_count    = '0;
                    n_tick     = '0;
                    res.status_valid = 1'b1;
                    res.status_code  = kfd_pkg::ST_OVERFLOW;
                end else begin
                    if (r_count == '0) begin
                        n_type = dec_byte;
                    end
                    res.data_valid = 1'b1;
                    res.data_byte  = dec_byte;
                    res.data_index = r_count;
                    n_count        = count_inc[9:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= kfd_pkg::MAX_LENGTH_RST;
            r_timeout    <= kfd_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kfd_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata[10:0];
                kfd_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_count     <= '0;
            r_type      <= '0;
            r_tick      <= '0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (adv) begin
                r_out_valid <= res_valid;
                if (r_in_valid) begin
                    r_in_frame <= n_in_frame;
                    r_esc      <= n_esc;
                    r_count    <= n_count;
                    r_type     <= n_type;
                    r_tick     <= n_tick;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in <= i_rx.payload;
        end
        if (adv) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/kfd_checker.sv
// Port-level checks on the KISS deframer result channel, bound to the top level.
// Depends on kfd_pkg and kiss_frame_deframer_core.
`default_nettype none

module kfd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire kfd_pkg::t_out_item i_res
);

    // every result is either a byte or a status, never both or neither
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res.data_valid != i_res.status_valid))
        else $error("result carries both or neither of data and status");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res.status_valid) |->
            (i_res.data_byte == 8'd0 && i_res.data_index == 10'd0))
        else $error("status result with non-zero data fields");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res.data_valid) |-> (i_res.status_code == kfd_pkg::ST_OK))
        else $error("data result with non-zero status code");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res)))
        else $error("stalled result changed");

endmodule

bind kiss_frame_deframer_core kfd_checker u_kfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);

`default_nettype wire
